/* sv/abbm_pkg.sv */
package abbm_pkg;

    localparam int W_IN   = 16;  // source box coordinate
    localparam int W_OUT  = 18;  // result coordinate
    localparam int W_DIFF = 18;  // coordinate minus origin
    localparam int W_SCL  = 34;  // scaled coordinate, Q.8
    localparam int W_PROD = 50;  // rotated term, Q.22
    localparam int W_SUM  = 52;  // corner value, Q.22
    localparam int Q_FRAC = 22;
    localparam int Q_DEPTH = 2;

    localparam logic signed [W_OUT-1:0] OUT_MAX = 18'sh1FFFF;
    localparam logic signed [W_OUT-1:0] OUT_MIN = 18'sh20000;
    localparam logic [W_SUM-1:0] FRAC_MASK = W_SUM'((64'd1 << Q_FRAC) - 64'd1);

    typedef enum logic [2:0] {
        CFG_ROTATE_COS = 3'd0,
        CFG_ROTATE_SIN = 3'd1,
        CFG_SCALE_X    = 3'd2,
        CFG_SCALE_Y    = 3'd3,
        CFG_SHIFT_X    = 3'd4,
        CFG_SHIFT_Y    = 3'd5,
        CFG_ORIGIN_X   = 3'd6,
        CFG_ORIGIN_Y   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] rotate_cos;
        logic signed [15:0] rotate_sin;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [16:0] shift_x;
        logic signed [16:0] shift_y;
        logic signed [16:0] origin_x;
        logic signed [16:0] origin_y;
    } t_cfg;

    // Scaled edges of one box, as passed from front to back
    typedef struct packed {
        logic signed [W_SCL-1:0] xs0;
        logic signed [W_SCL-1:0] xs1;
        logic signed [W_SCL-1:0] ys0;
        logic signed [W_SCL-1:0] ys1;
        logic                    first;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_SUM  = 2'd1,
        BK_CONV = 2'd2,
        BK_OUT  = 2'd3
    } t_bk_state;

    // Truncate a Q.22 value toward zero, then clamp to 18 bits signed
    function automatic logic signed [W_OUT-1:0] f_trunc_sat(input logic signed [W_SUM-1:0] q);
        logic [W_SUM-1:0]        b;
        logic [W_SUM-Q_FRAC-1:0] t;
        logic [W_SUM-Q_FRAC-W_OUT:0] hi;
        b  = q + (q[W_SUM-1] ? FRAC_MASK : '0);
        t  = b[W_SUM-1:Q_FRAC];
        hi = t[W_SUM-Q_FRAC-1:W_OUT-1];
        if ((&hi) || (~|hi)) begin
            return t[W_OUT-1:0];
        end else if (t[W_SUM-Q_FRAC-1]) begin
            return OUT_MIN;
        end else begin
            return OUT_MAX;
        end
    endfunction

endpackage

/* sv/abbm_front.sv */
module abbm_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  abbm_pkg::t_cfg           i_cfg,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [15:0]       i_box_left,
    input  logic signed [15:0]       i_box_bottom,
    input  logic signed [15:0]       i_box_right,
    input  logic signed [15:0]       i_box_top,
    input  logic                     i_first_box,
    input  abbm_pkg::t_q_stat        i_q_stat,
    output logic                     o_push,
    output abbm_pkg::t_item          o_item
);

    localparam int WD = abbm_pkg::W_DIFF;
    localparam int WS = abbm_pkg::W_SCL;

    logic                 r_valid;
    abbm_pkg::t_item      r_item;
    abbm_pkg::t_item      n_item;
    logic                 accept;
    logic signed [WD-1:0] dx0, dx1, dy0, dy1;

    assign o_push  = r_valid && !i_q_stat.full;
    assign o_stall = r_valid && i_q_stat.full;
    assign accept  = i_valid && !o_stall;
    assign o_item  = r_item;

    // Remove origin and scale each edge once; corners share them
    always_comb begin
        dx0 = WD'(i_box_left)   - WD'(i_cfg.origin_x);
        dx1 = WD'(i_box_right)  - WD'(i_cfg.origin_x);
        dy0 = WD'(i_box_bottom) - WD'(i_cfg.origin_y);
        dy1 = WD'(i_box_top)    - WD'(i_cfg.origin_y);
        n_item.xs0   = WS'(dx0) * WS'(i_cfg.scale_x);
        n_item.xs1   = WS'(dx1) * WS'(i_cfg.scale_x);
        n_item.ys0   = WS'(dy0) * WS'(i_cfg.scale_y);
        n_item.ys1   = WS'(dy1) * WS'(i_cfg.scale_y);
        n_item.first = i_first_box;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

/* sv/abbm_queue.sv */
module abbm_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  abbm_pkg::t_item    i_data,
    input  logic               i_pop,
    output abbm_pkg::t_item    o_data,
    output abbm_pkg::t_q_stat  o_stat
);

    localparam int DEPTH = abbm_pkg::Q_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    abbm_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* sv/abbm_back.sv */
module abbm_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  abbm_pkg::t_cfg           i_cfg,
    input  abbm_pkg::t_item          i_item,
    input  abbm_pkg::t_q_stat        i_q_stat,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [17:0]       o_new_left,
    output logic signed [17:0]       o_new_bottom,
    output logic signed [17:0]       o_new_right,
    output logic signed [17:0]       o_new_top,
    output logic signed [17:0]       o_union_left,
    output logic signed [17:0]       o_union_bottom,
    output logic signed [17:0]       o_union_right,
    output logic signed [17:0]       o_union_top
);

    localparam int WP = abbm_pkg::W_PROD;
    localparam int WU = abbm_pkg::W_SUM;
    localparam int WO = abbm_pkg::W_OUT;
    localparam int QF = abbm_pkg::Q_FRAC;

    abbm_pkg::t_bk_state  r_state, n_state;
    logic                 load;

    logic                 r_first;
    logic signed [WP-1:0] r_cx0, r_cx1, r_sy0, r_sy1, r_sx0, r_sx1, r_cy0, r_cy1;
    logic signed [WU-1:0] r_lo_x, r_hi_x, r_lo_y, r_hi_y;
    logic signed [WU-1:0] n_lo_x, n_hi_x, n_lo_y, n_hi_y;
    logic signed [WP-1:0] min_cx, max_cx, min_sy, max_sy;
    logic signed [WP-1:0] min_sx, max_sx, min_cy, max_cy;
    logic signed [WU-1:0] shx, shy;
    logic signed [WO-1:0] r_new_left, r_new_bottom, r_new_right, r_new_top;
    logic signed [WO-1:0] r_out_left, r_out_bottom, r_out_right, r_out_top;
    logic signed [WO-1:0] r_m_left, r_m_bottom, r_m_right, r_m_top;
    logic signed [WO-1:0] n_m_left, n_m_bottom, n_m_right, n_m_top;
    logic                 r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= abbm_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        load    = 1'b0;
        unique case (r_state)
            abbm_pkg::BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_state = abbm_pkg::BK_SUM;
                end
            end
            abbm_pkg::BK_SUM: begin
                n_state = abbm_pkg::BK_CONV;
            end
            abbm_pkg::BK_CONV: begin
                n_state = abbm_pkg::BK_OUT;
            end
            abbm_pkg::BK_OUT: begin
                if (!r_o_valid || !i_stall) begin
                    load    = 1'b1;
                    n_state = abbm_pkg::BK_IDLE;
                end
            end
        endcase
    end

    // Rotation terms straight off the queue head
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_first <= i_item.first;
            r_cx0   <= WP'(i_cfg.rotate_cos) * WP'(i_item.xs0);
            r_cx1   <= WP'(i_cfg.rotate_cos) * WP'(i_item.xs1);
            r_sy0   <= WP'(i_cfg.rotate_sin) * WP'(i_item.ys0);
            r_sy1   <= WP'(i_cfg.rotate_sin) * WP'(i_item.ys1);
            r_sx0   <= WP'(i_cfg.rotate_sin) * WP'(i_item.xs0);
            r_sx1   <= WP'(i_cfg.rotate_sin) * WP'(i_item.xs1);
            r_cy0   <= WP'(i_cfg.rotate_cos) * WP'(i_item.ys0);
            r_cy1   <= WP'(i_cfg.rotate_cos) * WP'(i_item.ys1);
        end
    end

    // x and y are separable over the corners: extremes come from the edge terms
    always_comb begin
        min_cx = (r_cx0 < r_cx1) ? r_cx0 : r_cx1;
        max_cx = (r_cx0 < r_cx1) ? r_cx1 : r_cx0;
        min_sy = (r_sy0 < r_sy1) ? r_sy0 : r_sy1;
        max_sy = (r_sy0 < r_sy1) ? r_sy1 : r_sy0;
        min_sx = (r_sx0 < r_sx1) ? r_sx0 : r_sx1;
        max_sx = (r_sx0 < r_sx1) ? r_sx1 : r_sx0;
        min_cy = (r_cy0 < r_cy1) ? r_cy0 : r_cy1;
        max_cy = (r_cy0 < r_cy1) ? r_cy1 : r_cy0;
        shx    = (WU'(i_cfg.shift_x)) <<< QF;
        shy    = (WU'(i_cfg.shift_y)) <<< QF;
        n_lo_x = WU'(min_cx) - WU'(max_sy) + shx;
        n_hi_x = WU'(max_cx) - WU'(min_sy) + shx;
        n_lo_y = WU'(min_sx) + WU'(min_cy) + shy;
        n_hi_y = WU'(max_sx) + WU'(max_cy) + shy;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == abbm_pkg::BK_SUM) begin
            r_lo_x <= n_lo_x;
            r_hi_x <= n_hi_x;
            r_lo_y <= n_lo_y;
            r_hi_y <= n_hi_y;
        end
        if (r_state == abbm_pkg::BK_CONV) begin
            r_new_left   <= abbm_pkg::f_trunc_sat(r_lo_x);
            r_new_bottom <= abbm_pkg::f_trunc_sat(r_lo_y);
            r_new_right  <= abbm_pkg::f_trunc_sat(r_hi_x);
            r_new_top    <= abbm_pkg::f_trunc_sat(r_hi_y);
        end
        if (load) begin
            r_out_left   <= r_new_left;
            r_out_bottom <= r_new_bottom;
            r_out_right  <= r_new_right;
            r_out_top    <= r_new_top;
        end
    end

    always_comb begin
        n_m_left   = (r_first || r_new_left < r_m_left)     ? r_new_left   : r_m_left;
        n_m_bottom = (r_first || r_new_bottom < r_m_bottom) ? r_new_bottom : r_m_bottom;
        n_m_right  = (r_first || r_new_right > r_m_right)   ? r_new_right  : r_m_right;
        n_m_top    = (r_first || r_new_top > r_m_top)       ? r_new_top    : r_m_top;
    end

    // Merge only when the result is handed over, so the union on show holds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_m_left   <= abbm_pkg::OUT_MAX;
            r_m_bottom <= abbm_pkg::OUT_MAX;
            r_m_right  <= abbm_pkg::OUT_MIN;
            r_m_top    <= abbm_pkg::OUT_MIN;
        end else begin
            if (load) begin
                r_o_valid  <= 1'b1;
                r_m_left   <= n_m_left;
                r_m_bottom <= n_m_bottom;
                r_m_right  <= n_m_right;
                r_m_top    <= n_m_top;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_o_valid;
    assign o_new_left     = r_out_left;
    assign o_new_bottom   = r_out_bottom;
    assign o_new_right    = r_out_right;
    assign o_new_top      = r_out_top;
    assign o_union_left   = r_m_left;
    assign o_union_bottom = r_m_bottom;
    assign o_union_right  = r_m_right;
    assign o_union_top    = r_m_top;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == abbm_pkg::BK_IDLE))
        else $error("queue popped outside idle");

    a_pop_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == abbm_pkg::BK_SUM))
        else $error("sequencer did not advance after pop");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_o_valid && r_state == abbm_pkg::BK_IDLE))
        else $error("result not shown after load");

    a_union_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_m_left <= r_out_left && r_m_bottom <= r_out_bottom &&
                       r_m_right >= r_out_right && r_m_top >= r_out_top))
        else $error("union does not cover the new box");

endmodule

/* sv/affine_bounding_box_merge_top.sv */
// The back-end sequencer takes one item at a time through its steps (pop and multiply,
// corner extremes, truncate, hand over) and pops the next only after the hand-over.
// Up to three items are taken ahead of the back end: the front register and a 2-entry queue.
// Reset (i_rst_n low at a clock edge, synchronous) empties the queue, clears the valids,
// restores the configuration defaults and sets the union to its empty box.
module affine_bounding_box_merge_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [16:0]        i_cfg_wdata,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_box_left,
    input  logic signed [15:0] i_box_bottom,
    input  logic signed [15:0] i_box_right,
    input  logic signed [15:0] i_box_top,
    input  logic               i_first_box,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [17:0] o_new_left,
    output logic signed [17:0] o_new_bottom,
    output logic signed [17:0] o_new_right,
    output logic signed [17:0] o_new_top,
    output logic signed [17:0] o_union_left,
    output logic signed [17:0] o_union_bottom,
    output logic signed [17:0] o_union_right,
    output logic signed [17:0] o_union_top
);

    abbm_pkg::t_cfg    r_cfg;
    abbm_pkg::t_item   front_item;
    abbm_pkg::t_item   head_item;
    abbm_pkg::t_q_stat q_stat;
    logic              push;
    logic              pop;

    // Configuration registers; the user must see that they are written only while the block is idle
    // (the block itself does not enforce this), so both halves read them directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotate_cos <= 16'sd16384;
            r_cfg.rotate_sin <= 16'sd0;
            r_cfg.scale_x    <= 16'sd256;
            r_cfg.scale_y    <= 16'sd256;
            r_cfg.shift_x    <= 17'sd0;
            r_cfg.shift_y    <= 17'sd0;
            r_cfg.origin_x   <= 17'sd0;
            r_cfg.origin_y   <= 17'sd0;
        end else if (i_cfg_we) begin
            unique case (abbm_pkg::t_cfg_idx'(i_cfg_addr))
                abbm_pkg::CFG_ROTATE_COS: r_cfg.rotate_cos <= i_cfg_wdata[15:0];
                abbm_pkg::CFG_ROTATE_SIN: r_cfg.rotate_sin <= i_cfg_wdata[15:0];
                abbm_pkg::CFG_SCALE_X:    r_cfg.scale_x    <= i_cfg_wdata[15:0];
                abbm_pkg::CFG_SCALE_Y:    r_cfg.scale_y    <= i_cfg_wdata[15:0];
                abbm_pkg::CFG_SHIFT_X:    r_cfg.shift_x    <= i_cfg_wdata;
                abbm_pkg::CFG_SHIFT_Y:    r_cfg.shift_y    <= i_cfg_wdata;
                abbm_pkg::CFG_ORIGIN_X:   r_cfg.origin_x   <= i_cfg_wdata;
                abbm_pkg::CFG_ORIGIN_Y:   r_cfg.origin_y   <= i_cfg_wdata;
            endcase
        end
    end

    // Front: take the item, drop the origin, scale the left, bottom, right and top edges
    abbm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_box_left   (i_box_left),
        .i_box_bottom (i_box_bottom),
        .i_box_right  (i_box_right),
        .i_box_top    (i_box_top),
        .i_first_box  (i_first_box),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_item       (front_item)
    );

    // Hold scaled items between the halves so each stalls on its own
    abbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .i_pop   (pop),
        .o_data  (head_item),
        .o_stat  (q_stat)
    );

    // Back: rotate, translate, take extremes, truncate, merge into the union
    abbm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_item         (head_item),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_new_left     (o_new_left),
        .o_new_bottom   (o_new_bottom),
        .o_new_right    (o_new_right),
        .o_new_top      (o_new_top),
        .o_union_left   (o_union_left),
        .o_union_bottom (o_union_bottom),
        .o_union_right  (o_union_right),
        .o_union_top    (o_union_top)
    );

endmodule
